// ----- sv/fplt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplt_pkg
// Shared types and constants for the framed pair level tracker: the per
// channel state word, the result word, the status codes and the register
// indexes of the configuration port.
// ----------------------------------------------------------------------------
package fplt_pkg;

  localparam int unsigned MAX_POINTS_DEF   = 400;
  localparam int unsigned NUM_CHANNELS_DEF = 4;

  // Wide enough for the largest supported point limit (4095).
  localparam int unsigned PointCntW = 12;

  localparam logic [15:0] MARKER_WORD = 16'h8000;

  // Register indexes of the configuration port.
  localparam logic CFG_HOLD_RELOAD = 1'b0;
  localparam logic CFG_INITIAL_MAX = 1'b1;

  typedef enum logic [1:0] {
    StSample = 2'd0,
    StMarker = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef struct packed {
    logic [PointCntW-1:0] count;
    logic [7:0]           hold;
    logic [15:0]          min_lvl;
    logic [15:0]          max_lvl;
    logic [15:0]          offset;
    logic                 b_high;
    logic                 active;
  } state_t;

  typedef struct packed {
    logic [1:0]  channel;
    status_e     status;
    logic [8:0]  sample_index;
    logic        point_logged;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [15:0] level_min;
    logic [15:0] level_mid;
    logic [15:0] level_max;
    logic        led_on;
    logic        last;
  } result_t;

endpackage

// ----- sv/framed_pair_level_tracker.sv -----
`timescale 1ns / 1ps
// Results: after the last byte of a frame is accepted, its results enter the
//   result queue one channel per cycle, channel zero first.
// Throughput: one byte per cycle. The last byte of a frame is held off while a
//   sweep runs or while the result queue lacks room for a whole frame's results.
// Reset: asynchronous, active low; configuration clears and all channel state
//   reads as zero at once through per-entry valid bits, so there is no clearing pass.
// ----------------------------------------------------------------------------
// framed_pair_level_tracker
// Frames serial bytes into per-channel sample pairs and tracks min, mid and
// max levels per channel with a read-modify-write pass over a state memory.
// ----------------------------------------------------------------------------
module framed_pair_level_tracker #(
  parameter int unsigned MaxPoints   = fplt_pkg::MAX_POINTS_DEF,
  parameter int unsigned NumChannels = fplt_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // Byte input channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  channel_o,
  output logic [1:0]  status_o,
  output logic [8:0]  sample_index_o,
  output logic        point_logged_o,
  output logic [15:0] value_a_o,
  output logic [15:0] value_b_o,
  output logic [15:0] level_min_o,
  output logic [15:0] level_mid_o,
  output logic [15:0] level_max_o,
  output logic        led_on_o,
  output logic        last_o
);

  localparam int unsigned ChW       = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  // Room for two frames' worth of results.
  localparam int unsigned FifoDepth = 2 * NumChannels;
  localparam int unsigned RsvW      = $clog2(FifoDepth + 1);

  // Configuration registers. The user must write them only while the block is idle; it is not enforced.
  logic [7:0]  hold_reload_q;
  logic [15:0] initial_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_reload_q <= '0;
      initial_max_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fplt_pkg::CFG_HOLD_RELOAD: hold_reload_q <= cfg_wdata_i[7:0];
        fplt_pkg::CFG_INITIAL_MAX: initial_max_q <= cfg_wdata_i;
        default:                   hold_reload_q <= hold_reload_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Byte intake. Bytes are always taken except the final byte of a frame, which
  // starts a sweep and needs the sweep idle and a whole frame of queue space.
  // ---------------------------------------------------------------------------
  logic            last_byte;
  logic            in_accept;
  logic            frame_done;
  logic [31:0]     frame_word;
  logic            sweep_busy_q;
  logic [ChW-1:0]  sweep_ch_q;
  logic [RsvW-1:0] rsv_q;

  assign in_ready_o = !last_byte ||
                      (!sweep_busy_q && rsv_q <= RsvW'(FifoDepth - NumChannels));
  assign in_accept  = in_valid_i && in_ready_o;
  assign frame_done = in_accept && last_byte;

  fplt_frame_mem #(
    .NumCh (NumChannels),
    .ChW   (ChW)
  ) u_frame_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .byte_i      (rx_byte_i),
    .last_byte_o (last_byte),
    .rd_addr_i   (sweep_ch_q),
    .rd_data_o   (frame_word)
  );

  // ---------------------------------------------------------------------------
  // Sweep: one channel per cycle is issued to both memories. Consecutive
  // sweeps are at least a frame of bytes apart, so a write-back never meets a
  // read of the same entry.
  // ---------------------------------------------------------------------------
  logic           s1_valid_q;
  logic [ChW-1:0] s1_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_busy_q <= 1'b0;
      sweep_ch_q   <= '0;
      s1_valid_q   <= 1'b0;
      s1_ch_q      <= '0;
    end else begin
      s1_valid_q <= sweep_busy_q;
      s1_ch_q    <= sweep_ch_q;
      if (frame_done) begin
        sweep_busy_q <= 1'b1;
        sweep_ch_q   <= '0;
      end else if (sweep_busy_q) begin
        if (sweep_ch_q == ChW'(NumChannels - 1)) begin
          sweep_busy_q <= 1'b0;
          sweep_ch_q   <= '0;
        end else begin
          sweep_ch_q <= sweep_ch_q + ChW'(1);
        end
      end
    end
  end

  // Stage 1: memory data is back; evaluate and write the state back.
  fplt_pkg::state_t  st_rd, st_nxt;
  fplt_pkg::result_t res_s1;

  fplt_state_mem #(
    .NumCh (NumChannels),
    .ChW   (ChW)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (sweep_ch_q),
    .rd_data_o (st_rd),
    .we_i      (s1_valid_q),
    .wr_addr_i (s1_ch_q),
    .wr_data_i (st_nxt)
  );

  fplt_chan_proc #(
    .MaxPoints (MaxPoints),
    .NumCh     (NumChannels),
    .ChW       (ChW)
  ) u_chan_proc (
    .ch_i          (s1_ch_q),
    .word_i        (frame_word),
    .st_i          (st_rd),
    .hold_reload_i (hold_reload_q),
    .initial_max_i (initial_max_q),
    .st_o          (st_nxt),
    .res_o         (res_s1)
  );

  // Stage 2: the midpoint is formed from the registered levels, then the
  // result is pushed into the queue.
  logic              s2_valid_q;
  fplt_pkg::result_t s2_res_q;
  fplt_pkg::result_t push_res;
  logic [15:0]       span;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_res_q <= res_s1;
  end

  always_comb begin
    span               = s2_res_q.level_max - s2_res_q.level_min;
    push_res           = s2_res_q;
    push_res.level_mid = {1'b0, span[15:1]} + s2_res_q.level_min;
  end

  fplt_pkg::result_t out_res;

  fplt_result_fifo #(
    .Depth (FifoDepth)
  ) u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .data_i  (push_res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  // Results promised but not yet delivered: queued plus in the pipeline.
  logic out_accept;
  assign out_accept = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_q <= '0;
    end else begin
      unique case ({frame_done, out_accept})
        2'b10:   rsv_q <= rsv_q + RsvW'(NumChannels);
        2'b11:   rsv_q <= rsv_q + RsvW'(NumChannels) - RsvW'(1);
        2'b01:   rsv_q <= rsv_q - RsvW'(1);
        default: rsv_q <= rsv_q;
      endcase
    end
  end

  assign channel_o      = out_res.channel;
  assign status_o       = 2'(out_res.status);
  assign sample_index_o = out_res.sample_index;
  assign point_logged_o = out_res.point_logged;
  assign value_a_o      = out_res.value_a;
  assign value_b_o      = out_res.value_b;
  assign level_min_o    = out_res.level_min;
  assign level_mid_o    = out_res.level_mid;
  assign level_max_o    = out_res.level_max;
  assign led_on_o       = out_res.led_on;
  assign last_o         = out_res.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_rsv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsv_q <= RsvW'(FifoDepth))
    else $error("reserved result count exceeds queue depth");

  a_sweep_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done |=> (sweep_busy_q && sweep_ch_q == '0))
    else $error("sweep did not start on channel zero after a frame");

  a_no_rmw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && sweep_busy_q) |-> (sweep_ch_q != s1_ch_q))
    else $error("state read and write-back hit the same channel");

endmodule

// ----- sv/fplt_frame_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplt_frame_mem
// Assembles incoming bytes into one 32-bit word per channel and keeps the
// words of the current frame in a small synchronous memory.
// ----------------------------------------------------------------------------
module fplt_frame_mem #(
  parameter int unsigned NumCh = fplt_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned ChW   = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     byte_i,
  output logic           last_byte_o,
  input  logic [ChW-1:0] rd_addr_i,
  output logic [31:0]    rd_data_o
);

  logic [1:0]     pos_q;
  logic [ChW-1:0] wch_q;
  logic [23:0]    shift_q;
  logic [31:0]    mem [NumCh];
  logic [31:0]    rd_data_q;

  assign last_byte_o = (pos_q == 2'd3) && (wch_q == ChW'(NumCh - 1));
  assign rd_data_o   = rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      wch_q <= '0;
    end else if (accept_i) begin
      pos_q <= pos_q + 2'd1;
      if (pos_q == 2'd3) begin
        wch_q <= (wch_q == ChW'(NumCh - 1)) ? '0 : wch_q + ChW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && pos_q != 2'd3) begin
      shift_q <= {shift_q[15:0], byte_i};
    end
  end

  // A word is written as its fourth byte arrives.
  always_ff @(posedge clk_i) begin
    if (accept_i && pos_q == 2'd3) begin
      mem[wch_q] <= {shift_q, byte_i};
    end
    rd_data_q <= mem[rd_addr_i];
  end

endmodule

// ----- sv/fplt_state_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplt_state_mem
// Per-channel tracking state in a synchronous memory with a registered
// read. Entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module fplt_state_mem #(
  parameter int unsigned NumCh = fplt_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned ChW   = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ChW-1:0]   rd_addr_i,
  output fplt_pkg::state_t rd_data_o,
  input  logic             we_i,
  input  logic [ChW-1:0]   wr_addr_i,
  input  fplt_pkg::state_t wr_data_i
);

  fplt_pkg::state_t mem [NumCh];
  fplt_pkg::state_t rd_data_q;
  logic [NumCh-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i] || (we_i && wr_addr_i == rd_addr_i);
    end
  end

  // Write-first forwarding when both ports address the same entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (we_i && wr_addr_i == rd_addr_i) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- sv/fplt_chan_proc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplt_chan_proc
// Evaluates one channel's sample pair against its stored state and gives
// the updated state and the result word, midpoint excluded.
// ----------------------------------------------------------------------------
module fplt_chan_proc #(
  parameter int unsigned MaxPoints = fplt_pkg::MAX_POINTS_DEF,
  parameter int unsigned NumCh     = fplt_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned ChW       = 2
) (
  input  logic [ChW-1:0]    ch_i,
  input  logic [31:0]       word_i,
  input  fplt_pkg::state_t  st_i,
  input  logic [7:0]        hold_reload_i,
  input  logic [15:0]       initial_max_i,
  output fplt_pkg::state_t  st_o,
  output fplt_pkg::result_t res_o
);

  localparam logic [fplt_pkg::PointCntW-1:0] Limit = fplt_pkg::PointCntW'(MaxPoints);

  function automatic logic [15:0] sub_clamp(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? a - b : 16'd0;
  endfunction

  logic [15:0] wa, wb, lo, va, vb, mn, mx;
  logic        is_marker, full, first;

  assign wa        = word_i[31:16];
  assign wb        = word_i[15:0];
  assign is_marker = (wa == fplt_pkg::MARKER_WORD);
  assign full      = (st_i.count >= Limit);
  assign first     = (st_i.count == '0);
  assign lo        = (wa < wb) ? wa : wb;

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    va    = '0;
    vb    = '0;
    mn    = st_i.min_lvl;
    mx    = st_i.max_lvl;
    res_o.channel      = 2'(ch_i);
    res_o.sample_index = 9'(st_i.count);
    res_o.last         = (ch_i == ChW'(NumCh - 1));
    priority if (is_marker) begin
      res_o.status = fplt_pkg::StMarker;
      st_o.count   = '0;
      st_o.active  = 1'b0;
      st_o.hold    = hold_reload_i;
    end else if (full) begin
      res_o.status = fplt_pkg::StFull;
    end else begin
      res_o.status = fplt_pkg::StSample;
      if (first) begin
        // First point: the aligned pair collapses onto the lower word.
        st_o.b_high = (wa < wb);
        st_o.offset = (wa < wb) ? wb - wa : wa - wb;
        va = lo;
        vb = lo;
        mn = lo;
        mx = (lo > initial_max_i) ? lo : initial_max_i;
      end else begin
        if (st_i.b_high) begin
          va = wa;
          vb = sub_clamp(wb, st_i.offset);
        end else begin
          va = sub_clamp(wa, st_i.offset);
          vb = wb;
        end
        if (va > mx) mx = va;
        if (vb > mx) mx = vb;
        if (va < mn) mn = va;
        if (vb < mn) mn = vb;
      end
      st_o.min_lvl = mn;
      st_o.max_lvl = mx;
      st_o.active  = 1'b1;
      if (st_i.hold == '0) begin
        st_o.count         = st_i.count + fplt_pkg::PointCntW'(1);
        res_o.point_logged = 1'b1;
      end else begin
        st_o.hold = st_i.hold - 8'd1;
      end
    end
    res_o.value_a   = va;
    res_o.value_b   = vb;
    res_o.level_min = st_o.min_lvl;
    res_o.level_max = st_o.max_lvl;
    res_o.led_on    = st_o.active && (st_o.count < Limit);
  end

endmodule

// ----- sv/fplt_result_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fplt_result_fifo
// Short result queue between the channel pipeline and the output port.
// ----------------------------------------------------------------------------
module fplt_result_fifo #(
  parameter int unsigned Depth = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fplt_pkg::result_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output fplt_pkg::result_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fplt_pkg::result_t buf_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < CntW'(Depth)))
    else $error("result queue written while full");

endmodule
